@@ design/tlq_pkg.sv @@
// ----------------------------------------------------------------------------
// tlq_pkg
// Shared types, constants and helpers for the thick line to quad corners block.
// ----------------------------------------------------------------------------
package tlq_pkg;

  localparam int FIFO_DEPTH = 2;    // default depth of the front-to-back queue
  localparam int ROOT_BITS  = 26;   // length, Q.4 units times 2^8
  localparam int RAD_BITS   = 52;   // squared length times 2^16, padded to even
  localparam int REM_BITS   = 28;
  localparam int QUO_BITS   = 12;   // offset magnitude never exceeds 2048
  localparam int NUM_BITS   = 38;
  localparam int PROD_BITS  = 28;

  typedef struct packed {
    logic signed [15:0] xs;
    logic signed [15:0] ys;
    logic signed [15:0] xe;
    logic signed [15:0] ye;
    logic        [11:0] w;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic               zero;
  } tlq_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_SQRT,
    ST_MUL,
    ST_DIVSET,
    ST_DIV,
    ST_EMIT
  } tlq_state_t;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767)       r = 16'sh7FFF;
    else if (v < -18'sd32768) r = 16'sh8000;
    else                      r = v[15:0];
    return r;
  endfunction

endpackage

@@ design/thick_line_to_quad_corners.sv @@
// ----------------------------------------------------------------------------
// thick_line_to_quad_corners
// Expands a Q12.4 line segment and a width into the four corners of its quad.
// ----------------------------------------------------------------------------
//  channel  | ports                              | handshake
//  ---------+------------------------------------+-------------------------------
//  input    | in_x/y_start, in_x/y_end,          | transfer when start && !busy
//           | in_line_width                      |
//  result   | out_corner_x/y, out_corner_index,  | transfer on out_valid, one
//           | out_last_corner                    | cycle, no back-pressure
//
//  Back end per segment: capture, square, sum, 26 square-root steps (one
//  result bit each), multiply, divider load, 12 shared-divisor steps, 4 corner
//  transfers; the square root is the longest. Zero-length segments are dropped.
//  The front queue accepts new segments while one is being worked; busy rises
//  only when the queue is full. rst_n is synchronous, active low, and clears
//  the queue and the sequencer. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module thick_line_to_quad_corners #(
  parameter int FIFO_DEPTH = tlq_pkg::FIFO_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_x_start,
  input  logic signed [15:0] in_y_start,
  input  logic signed [15:0] in_x_end,
  input  logic signed [15:0] in_y_end,
  input  logic        [11:0] in_line_width,
  output logic               out_valid,
  output logic signed [15:0] out_corner_x,
  output logic signed [15:0] out_corner_y,
  output logic        [1:0]  out_corner_index,
  output logic               out_last_corner
);

  // queued segment handed from front to back
  tlq_pkg::tlq_item_t item;
  logic               item_valid;
  logic               item_pop;

  tlq_front #(
    .DEPTH (FIFO_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_x_start    (in_x_start),
    .in_y_start    (in_y_start),
    .in_x_end      (in_x_end),
    .in_y_end      (in_y_end),
    .in_line_width (in_line_width),
    .item_valid    (item_valid),
    .item          (item),
    .item_pop      (item_pop)
  );

  // sequencer: sqrt, divide, emit four corners
  tlq_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_valid       (item_valid),
    .item             (item),
    .item_pop         (item_pop),
    .out_valid        (out_valid),
    .out_corner_x     (out_corner_x),
    .out_corner_y     (out_corner_y),
    .out_corner_index (out_corner_index),
    .out_last_corner  (out_last_corner)
  );

endmodule

@@ design/tlq_front.sv @@
// ----------------------------------------------------------------------------
// tlq_front
// Accepts segments, forms the direction and flags zero length, queues items.
// ----------------------------------------------------------------------------
module tlq_front #(
  parameter int DEPTH = tlq_pkg::FIFO_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic signed [15:0]  in_x_start,
  input  logic signed [15:0]  in_y_start,
  input  logic signed [15:0]  in_x_end,
  input  logic signed [15:0]  in_y_end,
  input  logic        [11:0]  in_line_width,
  output logic                item_valid,
  output tlq_pkg::tlq_item_t  item,
  input  logic                item_pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tlq_pkg::tlq_item_t q_r [DEPTH];
  tlq_pkg::tlq_item_t new_item;
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic push;

  assign busy       = (count_r == CW'(DEPTH));
  assign push       = start && !busy;
  assign item_valid = (count_r != '0);
  assign item       = q_r[rd_ptr_r];

  always_comb begin
    new_item.xs   = in_x_start;
    new_item.ys   = in_y_start;
    new_item.xe   = in_x_end;
    new_item.ye   = in_y_end;
    new_item.w    = in_line_width;
    new_item.dx   = 17'(in_x_end) - 17'(in_x_start);
    new_item.dy   = 17'(in_y_end) - 17'(in_y_start);
    new_item.zero = (in_x_end == in_x_start) && (in_y_end == in_y_start);
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (item_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !item_pop)      count_nxt = count_r + 1'b1;
    else if (!push && item_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= new_item;
  end

endmodule

@@ design/tlq_back.sv @@
// ----------------------------------------------------------------------------
// tlq_back
// Length by bit-serial square root, offsets by shift-subtract division,
// then four corner transfers.
// ----------------------------------------------------------------------------
module tlq_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  input  tlq_pkg::tlq_item_t  item,
  output logic                item_pop,
  output logic                out_valid,
  output logic signed [15:0]  out_corner_x,
  output logic signed [15:0]  out_corner_y,
  output logic        [1:0]   out_corner_index,
  output logic                out_last_corner
);

  localparam int RB = tlq_pkg::ROOT_BITS;
  localparam int MB = tlq_pkg::RAD_BITS;
  localparam int EB = tlq_pkg::REM_BITS;
  localparam int QB = tlq_pkg::QUO_BITS;
  localparam int NB = tlq_pkg::NUM_BITS;
  localparam int PB = tlq_pkg::PROD_BITS;

  tlq_pkg::tlq_state_t state_r, state_nxt;
  tlq_pkg::tlq_item_t  item_r;
  logic [4:0]          cnt_r;
  logic [33:0]         sqx_r, sqy_r;
  logic [MB-1:0]       rad_r;
  logic [EB-1:0]       rem_r;
  logic [RB-1:0]       root_r;
  logic [PB-1:0]       prodx_r, prody_r;
  logic [NB-1:0]       numx_r, numy_r, dsh_r;
  logic [QB-1:0]       qx_r, qy_r;
  logic                out_valid_r;
  logic signed [15:0]  out_x_r, out_y_r;
  logic [1:0]          out_idx_r;
  logic                out_last_r;

  logic [EB+1:0]       sq_tmp, sq_trial;
  logic [15:0]         mag_x, mag_y;
  logic signed [12:0]  px, py;
  logic signed [17:0]  base_x, base_y, off_x, off_y;
  logic                last_step;

  assign out_valid        = out_valid_r;
  assign out_corner_x     = out_x_r;
  assign out_corner_y     = out_y_r;
  assign out_corner_index = out_idx_r;
  assign out_last_corner  = out_last_r;

  // offset x uses -dy, offset y uses dx
  assign mag_x = item_r.dy[16] ? 16'(-item_r.dy) : item_r.dy[15:0];
  assign mag_y = item_r.dx[16] ? 16'(-item_r.dx) : item_r.dx[15:0];
  assign px    = (!item_r.dy[16] && item_r.dy != '0) ? -$signed({1'b0, qx_r})
                                                     :  $signed({1'b0, qx_r});
  assign py    = item_r.dx[16] ? -$signed({1'b0, qy_r}) : $signed({1'b0, qy_r});

  assign sq_tmp   = {rem_r, rad_r[MB-1 -: 2]};
  assign sq_trial = {2'b00, root_r, 2'b01};

  always_comb begin
    last_step = 1'b0;
    unique case (state_r)
      tlq_pkg::ST_SQRT: last_step = (cnt_r == 5'(RB - 1));
      tlq_pkg::ST_DIV:  last_step = (cnt_r == 5'(QB - 1));
      tlq_pkg::ST_EMIT: last_step = (cnt_r == 5'd3);
      default:          last_step = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tlq_pkg::ST_IDLE:   if (item_valid && !item.zero) state_nxt = tlq_pkg::ST_SQUARE;
      tlq_pkg::ST_SQUARE: state_nxt = tlq_pkg::ST_SUM;
      tlq_pkg::ST_SUM:    state_nxt = tlq_pkg::ST_SQRT;
      tlq_pkg::ST_SQRT:   if (last_step) state_nxt = tlq_pkg::ST_MUL;
      tlq_pkg::ST_MUL:    state_nxt = tlq_pkg::ST_DIVSET;
      tlq_pkg::ST_DIVSET: state_nxt = tlq_pkg::ST_DIV;
      tlq_pkg::ST_DIV:    if (last_step) state_nxt = tlq_pkg::ST_EMIT;
      tlq_pkg::ST_EMIT:   if (last_step) state_nxt = tlq_pkg::ST_IDLE;
      default:            state_nxt = tlq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    item_pop = 1'b0;
    base_x   = 18'(item_r.xs);
    base_y   = 18'(item_r.ys);
    off_x    = 18'(px);
    off_y    = 18'(py);
    unique case (state_r)
      tlq_pkg::ST_IDLE: item_pop = item_valid;
      tlq_pkg::ST_EMIT: begin
        // fan order: start+off, start-off, end-off, end+off
        if (cnt_r[1]) begin
          base_x = 18'(item_r.xe);
          base_y = 18'(item_r.ye);
        end
        if (cnt_r[1] ^ cnt_r[0]) begin
          off_x = -18'(px);
          off_y = -18'(py);
        end
      end
      default: item_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tlq_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == tlq_pkg::ST_EMIT);
      if (last_step || state_r == tlq_pkg::ST_SUM || state_r == tlq_pkg::ST_DIVSET)
        cnt_r <= '0;
      else if (state_r == tlq_pkg::ST_SQRT || state_r == tlq_pkg::ST_DIV ||
               state_r == tlq_pkg::ST_EMIT)
        cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      tlq_pkg::ST_IDLE: if (item_valid) item_r <= item;
      tlq_pkg::ST_SQUARE: begin
        sqx_r <= 34'(item_r.dx * item_r.dx);
        sqy_r <= 34'(item_r.dy * item_r.dy);
      end
      tlq_pkg::ST_SUM: begin
        rad_r  <= {2'b00, sqx_r + sqy_r, 16'h0000};
        rem_r  <= '0;
        root_r <= '0;
      end
      tlq_pkg::ST_SQRT: begin
        rad_r <= {rad_r[MB-3:0], 2'b00};
        if (sq_tmp >= sq_trial) begin
          rem_r  <= EB'(sq_tmp - sq_trial);
          root_r <= {root_r[RB-2:0], 1'b1};
        end else begin
          rem_r  <= EB'(sq_tmp);
          root_r <= {root_r[RB-2:0], 1'b0};
        end
      end
      tlq_pkg::ST_MUL: begin
        prodx_r <= PB'(mag_x * item_r.w);
        prody_r <= PB'(mag_y * item_r.w);
      end
      tlq_pkg::ST_DIVSET: begin
        numx_r <= {2'b00, prodx_r, 8'h00} + NB'(root_r);
        numy_r <= {2'b00, prody_r, 8'h00} + NB'(root_r);
        dsh_r  <= {root_r, 1'b0, 11'h000};
        qx_r   <= '0;
        qy_r   <= '0;
      end
      tlq_pkg::ST_DIV: begin
        dsh_r <= dsh_r >> 1;
        if (numx_r >= dsh_r) begin
          numx_r <= numx_r - dsh_r;
          qx_r   <= {qx_r[QB-2:0], 1'b1};
        end else begin
          qx_r   <= {qx_r[QB-2:0], 1'b0};
        end
        if (numy_r >= dsh_r) begin
          numy_r <= numy_r - dsh_r;
          qy_r   <= {qy_r[QB-2:0], 1'b1};
        end else begin
          qy_r   <= {qy_r[QB-2:0], 1'b0};
        end
      end
      tlq_pkg::ST_EMIT: begin
        out_x_r    <= tlq_pkg::sat16(base_x + off_x);
        out_y_r    <= tlq_pkg::sat16(base_y + off_y);
        out_idx_r  <= cnt_r[1:0];
        out_last_r <= (cnt_r == 5'd3);
      end
      default: ;
    endcase
  end

endmodule
